/* rtl/lbpc_pkg.sv */
// shared types and constants for the led blink pattern controller
`default_nettype none

package lbpc_pkg;

    // slave-side transfer layout
    localparam int ACTION_W   = 3;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 15;
    localparam int EDGES_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int S_TDATA_W  = 152;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK          = 3'd0,
        ACT_BLINK_COUNTED = 3'd1,
        ACT_BLINK_FOREVER = 3'd2,
        ACT_STOP          = 3'd3,
        ACT_LOAD_STEP     = 3'd4,
        ACT_START_PATTERN = 3'd5
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   time_now;
        logic [COUNT_W-1:0]  blink_count;
        logic [TIME_W-1:0]   on_time;
        logic [TIME_W-1:0]   off_time;
        logic [INDEX_W-1:0]  step_index;
        logic                step_level;
        logic [TIME_W-1:0]   step_hold;
    } t_item;

    typedef struct packed {
        logic pattern_running;
        logic blink_running;
        logic accepted;
        logic led_level;
    } t_result;

    typedef struct packed {
        logic              en;
        logic              level;
        logic [TIME_W-1:0] hold;
    } t_tbl_wr;

endpackage

`default_nettype wire

/* rtl/lbpc_table.sv */
// pattern step storage: one write port, one registered read port
`default_nettype none

module lbpc_table
    import lbpc_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16,
    parameter int AW            = 4
) (
    input  wire logic              i_clk,
    input  wire t_tbl_wr           i_wr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic                   o_rd_level,
    output logic [TIME_W-1:0]      o_rd_hold
);

    logic [TIME_W:0] r_mem [PATTERN_DEPTH];
    logic [TIME_W:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= {i_wr.level, i_wr.hold};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_level = r_rd_data[TIME_W];
    assign o_rd_hold  = r_rd_data[TIME_W-1:0];

endmodule

`default_nettype wire

/* rtl/lbpc_engine.sv */
// command decode, blink and pattern state, and per-item result
`default_nettype none

module lbpc_engine
    import lbpc_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16,
    parameter int AW            = 4,
    parameter int LW            = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_item             i_item,
    input  wire logic              i_rd_level,
    input  wire logic [TIME_W-1:0] i_rd_hold,
    output t_result                o_result,
    output t_tbl_wr                o_wr,
    output logic [AW-1:0]          o_wr_addr,
    output logic [AW-1:0]          o_rd_addr
);

    localparam int CW = (AW > INDEX_W) ? AW : INDEX_W;

    logic               r_led,       n_led;
    logic               r_active,    n_active;
    logic               r_forever,   n_forever;
    logic               r_phase_lit, n_phase_lit;
    logic [EDGES_W-1:0] r_edges,     n_edges;
    logic [TIME_W-1:0]  r_bdl,       n_bdl;
    logic [TIME_W-1:0]  r_lit,       n_lit;
    logic [TIME_W-1:0]  r_dark,      n_dark;
    logic [LW-1:0]      r_plen,      n_plen;
    logic [LW-1:0]      r_pos,       n_pos;
    logic [TIME_W-1:0]  r_pdl,       n_pdl;

    logic               ok;
    logic [LW-1:0]      pos_inc;
    logic [EDGES_W-1:0] edges_dec;
    logic [CW-1:0]      idx_ext;
    logic               idx_bad;
    logic               len_bad;

    // deadline reached when (now - target) is non-negative as signed
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] target);
        logic [TIME_W-1:0] diff;
        diff = now - target;
        return !diff[TIME_W-1];
    endfunction

    assign pos_inc   = r_pos + LW'(1);
    assign edges_dec = r_edges - EDGES_W'(1);
    assign idx_ext   = CW'(i_item.step_index);
    assign idx_bad   = 32'(i_item.step_index) >= 32'(PATTERN_DEPTH);
    assign len_bad   = (i_item.blink_count == '0)
                    || (32'(i_item.blink_count) > 32'(PATTERN_DEPTH));

    always_comb begin
        n_led       = r_led;
        n_active    = r_active;
        n_forever   = r_forever;
        n_phase_lit = r_phase_lit;
        n_edges     = r_edges;
        n_bdl       = r_bdl;
        n_lit       = r_lit;
        n_dark      = r_dark;
        n_plen      = r_plen;
        n_pos       = r_pos;
        n_pdl       = r_pdl;
        ok          = 1'b1;
        o_wr.en     = 1'b0;
        o_wr.level  = i_item.step_level;
        o_wr.hold   = i_item.step_hold;

        unique case (i_item.action)
            ACT_TICK: begin
                if (r_plen != '0) begin
                    if (reached(i_item.time_now, r_pdl)) begin
                        n_led = i_rd_level;
                        n_pos = pos_inc;
                        if (pos_inc >= r_plen) begin
                            n_plen = '0;
                        end else begin
                            n_pdl = i_item.time_now + i_rd_hold;
                        end
                    end
                end else if (r_active && reached(i_item.time_now, r_bdl)) begin
                    if (r_phase_lit) begin
                        n_led       = 1'b0;
                        n_phase_lit = 1'b0;
                        if (!r_forever) begin
                            n_edges = edges_dec;
                        end
                        if (!r_forever && edges_dec == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_bdl = i_item.time_now + r_dark;
                        end
                    end else begin
                        n_led       = 1'b1;
                        n_phase_lit = 1'b1;
                        if (!r_forever) begin
                            n_edges = edges_dec;
                        end
                        n_bdl = i_item.time_now + r_lit;
                    end
                end
            end
            ACT_BLINK_COUNTED, ACT_BLINK_FOREVER: begin
                if (i_item.action == ACT_BLINK_COUNTED && i_item.blink_count == '0) begin
                    n_plen   = '0;
                    n_active = 1'b0;
                    n_led    = 1'b0;
                end else begin
                    n_plen      = '0;
                    n_active    = 1'b1;
                    n_forever   = (i_item.action == ACT_BLINK_FOREVER);
                    n_phase_lit = 1'b1;
                    n_edges     = (i_item.action == ACT_BLINK_FOREVER) ? '0
                                : {i_item.blink_count, 1'b0} - EDGES_W'(1);
                    n_bdl       = i_item.time_now + i_item.on_time;
                    n_lit       = i_item.on_time;
                    n_dark      = i_item.off_time;
                    n_led       = 1'b1;
                end
            end
            ACT_STOP: begin
                n_plen      = '0;
                n_active    = 1'b0;
                n_forever   = 1'b0;
                n_phase_lit = 1'b0;
                n_edges     = '0;
                n_bdl       = '0;
                n_lit       = '0;
                n_dark      = '0;
                n_led       = 1'b0;
            end
            ACT_LOAD_STEP: begin
                if (r_plen != '0 || idx_bad) begin
                    ok = 1'b0;
                end else begin
                    o_wr.en = 1'b1;
                end
            end
            ACT_START_PATTERN: begin
                if (len_bad) begin
                    ok = 1'b0;
                end else begin
                    n_active    = 1'b0;
                    n_forever   = 1'b0;
                    n_phase_lit = 1'b0;
                    n_edges     = '0;
                    n_bdl       = '0;
                    n_lit       = '0;
                    n_dark      = '0;
                    n_plen      = LW'(i_item.blink_count);
                    n_pos       = '0;
                    n_pdl       = i_item.time_now;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (!i_fire) begin
            o_wr.en = 1'b0;
        end
    end

    assign o_result.led_level       = n_led;
    assign o_result.accepted        = ok;
    assign o_result.blink_running   = n_active;
    assign o_result.pattern_running = (n_plen != '0);

    assign o_wr_addr = idx_ext[AW-1:0];

    // prefetch the step the next tick will apply; hold address while stalled
    always_comb begin
        logic [LW-1:0] nxt;
        nxt = i_fire ? n_pos : r_pos;
        o_rd_addr = (nxt < LW'(PATTERN_DEPTH)) ? nxt[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led       <= 1'b0;
            r_active    <= 1'b0;
            r_forever   <= 1'b0;
            r_phase_lit <= 1'b0;
            r_edges     <= '0;
            r_bdl       <= '0;
            r_lit       <= '0;
            r_dark      <= '0;
            r_plen      <= '0;
            r_pos       <= '0;
            r_pdl       <= '0;
        end else if (i_fire) begin
            r_led       <= n_led;
            r_active    <= n_active;
            r_forever   <= n_forever;
            r_phase_lit <= n_phase_lit;
            r_edges     <= n_edges;
            r_bdl       <= n_bdl;
            r_lit       <= n_lit;
            r_dark      <= n_dark;
            r_plen      <= n_plen;
            r_pos       <= n_pos;
            r_pdl       <= n_pdl;
        end
    end

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LW'(PATTERN_DEPTH))
        else $error("pattern length beyond table depth");

    a_pos_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen != '0) |-> (r_pos < r_plen))
        else $error("pattern position past length while playing");

    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_active && (r_plen != '0)))
        else $error("blink and pattern both running");

    a_no_load_while_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_plen == '0))
        else $error("table write during playback");

endmodule

`default_nettype wire

/* rtl/led_blink_pattern_controller_core.sv */
// top level of the led blink pattern controller
`default_nettype none

// Drives one LED from timed commands, each carrying the current millisecond
// time. One command transfer is taken every clock cycle at full rate while
// the status side keeps draining: the command is held in an input register,
// its whole effect is worked out by adds and compares against the stored
// state, and the status is caught in an output register, from which it is
// taken. The pattern table is a memory with one write port and one
// registered read port, and the read is prefetched at the step the next
// tick will play, which is what lets a tick complete without waiting on a
// table read. The output register parts the two sides: one more command is
// still taken into the input register while a status waits, and only then
// does the input stall. Ticks apply at most one due transition; pattern
// playback wins over blinking, and loads while playing or with a bad index
// are refused.
module led_blink_pattern_controller_core
    import lbpc_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // time_now[31:0], blink_count[46:32], on_time[78:47], off_time[110:79],
    // step_index[114:111], step_level[115], step_hold[147:116], zero pad
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // action[2:0]
    input  wire logic [ACTION_W-1:0]  i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // led_level[0], accepted[1], blink_running[2], pattern_running[3], zero pad
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LW = $clog2(PATTERN_DEPTH + 1);

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_result;

    logic              fire;
    t_result           result;
    t_tbl_wr           tbl_wr;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              rd_level;
    logic [TIME_W-1:0] rd_hold;

    // a command is worked off when the result slot is free or being drained
    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_item.action      <= i_s_axis_tuser;
            r_item.time_now    <= i_s_axis_tdata[31:0];
            r_item.blink_count <= i_s_axis_tdata[46:32];
            r_item.on_time     <= i_s_axis_tdata[78:47];
            r_item.off_time    <= i_s_axis_tdata[110:79];
            r_item.step_index  <= i_s_axis_tdata[114:111];
            r_item.step_level  <= i_s_axis_tdata[115];
            r_item.step_hold   <= i_s_axis_tdata[147:116];
        end
    end

    lbpc_engine #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .AW            (AW),
        .LW            (LW)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_item),
        .i_rd_level (rd_level),
        .i_rd_hold  (rd_hold),
        .o_result   (result),
        .o_wr       (tbl_wr),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr)
    );

    lbpc_table #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .AW            (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr       (tbl_wr),
        .i_wr_addr  (wr_addr),
        .i_rd_addr  (rd_addr),
        .o_rd_level (rd_level),
        .o_rd_hold  (rd_hold)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_result.pattern_running, r_result.blink_running,
                              r_result.accepted, r_result.led_level};

endmodule

`default_nettype wire
